// File: design/tsr_pkg.sv
package tsr_pkg;

    localparam logic [7:0] FL_FIN = 8'h01;
    localparam logic [7:0] FL_SYN = 8'h02;
    localparam logic [7:0] FL_RST = 8'h04;
    localparam logic [7:0] FL_PSH = 8'h08;
    localparam logic [7:0] FL_ACK = 8'h10;

    localparam logic [5:0] IDLE_INDEX = 6'd63;
    localparam logic [5:0] MIN_END_INDEX = 6'd19;

    localparam logic [7:0] OFFSET_PLAIN = 8'h50;
    localparam logic [7:0] OFFSET_OPT = 8'h60;
    localparam logic [7:0] OPT_KIND_MSS = 8'h02;
    localparam logic [7:0] OPT_LEN_MSS = 8'h04;
    localparam logic [15:0] PROTO_TCP = 16'd6;

    localparam logic [4:0] LEN_PLAIN = 5'd20;
    localparam logic [4:0] LEN_OPT = 5'd24;

    localparam logic [15:0] LISTEN_PORT_RST = 16'd80;
    localparam logic [15:0] MSS_RST = 16'd536;

    typedef enum logic [1:0] {
        CFG_LOCAL_IP = 2'd0,
        CFG_LISTEN_PORT = 2'd1,
        CFG_WINDOW_SIZE = 2'd2,
        CFG_MAX_SEG_SIZE = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic        valid;
        logic        app;
        logic        opt;
        logic [15:0] own_port;
        logic [15:0] peer_port;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [7:0]  flags;
        logic [31:0] peer_ip;
    } emit_req_t;

endpackage

// File: design/tcp_segment_responder_core.sv
// channel | dir | tdata (low bit up)                                 | tlast     | tuser
// s_      | in  | header_byte, ip_total_len, peer_ip, isn_value      | -         | segment_start
// m_      | out | out_byte, reply_length, zero fill                  | last_byte | event_kind
// cfg_    | in  | cfg_index selects register, cfg_data value         | -         | -
// one header byte per cycle unless stalled; parse state updates at the edge that takes the byte
// a reply is 20 or 24 words, one per cycle while the output register is free; the
// final header byte sets busy, then the first word is loaded; an application event is one word
// the serial checksum adder finishes before byte 16 is loaded; that byte waits for it
// the final byte of a segment stalls while the emitter is still busy with the previous reply
// reset clears parse state and sets the registers to their defaults
module tcp_segment_responder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,  // header_byte, ip_total_len, peer_ip, isn_value
    input  logic        s_tuser,  // segment_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // out_byte, reply_length, zero fill
    output logic        m_tlast,  // last_byte
    output logic        m_tuser,  // event_kind
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import tsr_pkg::*;

    logic [31:0] local_ip_reg;
    logic [15:0] listen_port_reg;
    logic [15:0] window_size_reg;
    logic [15:0] max_seg_size_reg;

    logic [5:0]  idx_reg, idx_next;
    logic [15:0] peer_port_reg, peer_port_next;
    logic [15:0] own_port_reg, own_port_next;
    logic [31:0] rx_seq_reg, rx_seq_next;
    logic [31:0] rx_ack_reg, rx_ack_next;
    logic [3:0]  hw_reg, hw_next;
    logic [7:0]  flags_reg, flags_next;
    logic [31:0] reply_seq_reg, reply_seq_next;
    logic [31:0] reply_ack_reg, reply_ack_next;
    logic [7:0]  reply_flags_reg, reply_flags_next;

    logic [7:0]  in_byte;
    logic [15:0] in_total_len;
    logic [31:0] in_peer_ip;
    logic [31:0] in_isn;
    logic        accept;
    logic [5:0]  idx;
    logic [5:0]  end_idx;
    logic [5:0]  end_idx_state;
    logic        state_end;
    logic        seg_end;
    logic [17:0] dl;
    logic [15:0] datalen;
    logic        to_listen;
    logic        emit_busy;
    emit_req_t   req;

    assign in_byte = s_tdata[7:0];
    assign in_total_len = s_tdata[23:8];
    assign in_peer_ip = s_tdata[55:24];
    assign in_isn = s_tdata[87:56];

    assign end_idx_state = (hw_reg > 4'd5) ? {hw_reg, 2'b00} - 6'd1 : MIN_END_INDEX;
    assign state_end = (idx_reg != IDLE_INDEX) && (idx_reg >= MIN_END_INDEX)
                       && (idx_reg == end_idx_state);
    assign s_tready = !(emit_busy && state_end);
    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg <= 32'd0;
            listen_port_reg <= LISTEN_PORT_RST;
            window_size_reg <= 16'd0;
            max_seg_size_reg <= MSS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_LOCAL_IP:     local_ip_reg <= cfg_data;
                CFG_LISTEN_PORT:  listen_port_reg <= cfg_data[15:0];
                CFG_WINDOW_SIZE:  window_size_reg <= cfg_data[15:0];
                CFG_MAX_SEG_SIZE: max_seg_size_reg <= cfg_data[15:0];
                default:          local_ip_reg <= local_ip_reg;
            endcase
        end
    end

    assign to_listen = (own_port_next == listen_port_reg);
    assign dl = {2'b00, in_total_len} - 18'd20 - {12'd0, hw_next, 2'b00};
    assign datalen = dl[17] ? 16'd0 : dl[15:0];

    always_comb
    begin
        idx = s_tuser ? 6'd0 : idx_reg;
        idx_next = idx_reg;
        peer_port_next = peer_port_reg;
        own_port_next = own_port_reg;
        rx_seq_next = rx_seq_reg;
        rx_ack_next = rx_ack_reg;
        hw_next = hw_reg;
        flags_next = flags_reg;
        reply_seq_next = reply_seq_reg;
        reply_ack_next = reply_ack_reg;
        reply_flags_next = reply_flags_reg;
        end_idx = MIN_END_INDEX;
        seg_end = 1'b0;
        req = '0;

        if (accept)
        begin
            idx_next = idx;
        end
        if (accept && idx != IDLE_INDEX)
        begin
            if (idx < 6'd2)
            begin
                peer_port_next = {peer_port_reg[7:0], in_byte};
            end
            else if (idx < 6'd4)
            begin
                own_port_next = {own_port_reg[7:0], in_byte};
            end
            else if (idx < 6'd8)
            begin
                rx_seq_next = {rx_seq_reg[23:0], in_byte};
            end
            else if (idx < 6'd12)
            begin
                rx_ack_next = {rx_ack_reg[23:0], in_byte};
            end
            else if (idx == 6'd12)
            begin
                hw_next = in_byte[7:4];
            end
            else if (idx == 6'd13)
            begin
                flags_next = in_byte;
            end

            end_idx = (hw_next > 4'd5) ? {hw_next, 2'b00} - 6'd1 : MIN_END_INDEX;
            seg_end = (idx >= MIN_END_INDEX) && (idx == end_idx);
            idx_next = seg_end ? IDLE_INDEX : idx + 6'd1;
        end

        if (seg_end && !((flags_next & FL_RST) != 8'd0) && flags_next != FL_ACK)
        begin
            req.valid = 1'b1;
            if ((flags_next & FL_SYN) != 8'd0)
            begin
                reply_seq_next = in_isn;
                reply_ack_next = rx_seq_next + 32'd1;
                if (to_listen)
                begin
                    reply_flags_next = FL_SYN | FL_ACK;
                    req.opt = 1'b1;
                end
                else
                begin
                    reply_flags_next = FL_RST | FL_ACK;
                end
            end
            else if ((flags_next & FL_FIN) != 8'd0)
            begin
                reply_seq_next = rx_ack_next;
                reply_ack_next = rx_seq_next + 32'(datalen) + 32'd1;
                reply_flags_next = FL_ACK;
            end
            else if ((flags_next & FL_ACK) != 8'd0)
            begin
                reply_seq_next = rx_ack_next;
                reply_ack_next = rx_seq_next + 32'(datalen);
                if (datalen == 16'd0 || !to_listen)
                begin
                    req.valid = 1'b0;
                end
                else
                begin
                    reply_flags_next = FL_FIN | FL_PSH | FL_ACK;
                    req.app = 1'b1;
                end
            end
        end

        req.own_port = own_port_next;
        req.peer_port = peer_port_next;
        req.seq = reply_seq_next;
        req.ack = reply_ack_next;
        req.flags = reply_flags_next;
        req.peer_ip = in_peer_ip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 6'd0;
            peer_port_reg <= 16'd0;
            own_port_reg <= 16'd0;
            rx_seq_reg <= 32'd0;
            rx_ack_reg <= 32'd0;
            hw_reg <= 4'd0;
            flags_reg <= 8'd0;
            reply_seq_reg <= 32'd0;
            reply_ack_reg <= 32'd0;
            reply_flags_reg <= 8'd0;
        end
        else
        begin
            idx_reg <= idx_next;
            peer_port_reg <= peer_port_next;
            own_port_reg <= own_port_next;
            rx_seq_reg <= rx_seq_next;
            rx_ack_reg <= rx_ack_next;
            hw_reg <= hw_next;
            flags_reg <= flags_next;
            reply_seq_reg <= reply_seq_next;
            reply_ack_reg <= reply_ack_next;
            reply_flags_reg <= reply_flags_next;
        end
    end

    tsr_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .local_ip     (local_ip_reg),
        .window_size  (window_size_reg),
        .max_seg_size (max_seg_size_reg),
        .busy         (emit_busy),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser)
    );

`ifndef SYNTHESIS
    a_end_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_busy && state_end) |-> !s_tready)
        else $error("segment end accepted while reply in progress");
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg == IDLE_INDEX && !(accept && s_tuser)) |=> (idx_reg == IDLE_INDEX))
        else $error("left idle without a start mark");
    a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        seg_end |=> (idx_reg == IDLE_INDEX))
        else $error("segment end did not enter idle");
`endif

endmodule

// File: design/tsr_emit.sv
module tsr_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  tsr_pkg::emit_req_t req,
    input  logic [31:0]       local_ip,
    input  logic [15:0]       window_size,
    input  logic [15:0]       max_seg_size,
    output logic              busy,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,  // out_byte, reply_length, zero fill
    output logic              m_tlast,  // last_byte
    output logic              m_tuser   // event_kind
);
    import tsr_pkg::*;

    localparam logic [3:0] TERMS = 4'd15;

    logic        busy_reg, busy_next;
    logic        app_reg;
    logic        opt_reg;
    logic [4:0]  pos_reg, pos_next;
    logic [3:0]  term_reg, term_next;
    logic [19:0] sum_reg, sum_next;
    logic [15:0] own_port_reg;
    logic [15:0] peer_port_reg;
    logic [31:0] seq_reg;
    logic [31:0] ack_reg;
    logic [7:0]  flags_reg;
    logic [31:0] peer_ip_reg;

    logic        ovalid_reg, ovalid_next;
    logic [7:0]  obyte_reg;
    logic        olast_reg;
    logic        okind_reg;
    logic [4:0]  olen_reg;

    logic [4:0]  len;
    logic        out_free;
    logic        need_sum;
    logic        sum_done;
    logic        load;
    logic        last_load;
    logic [15:0] term_val;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [15:0] csum;
    logic [7:0]  hdr_byte;
    logic [7:0]  byte_sel;

    assign len = opt_reg ? LEN_OPT : LEN_PLAIN;
    assign hdr_byte = opt_reg ? OFFSET_OPT : OFFSET_PLAIN;
    assign out_free = !ovalid_reg || m_tready;
    assign need_sum = (pos_reg == 5'd16) || (pos_reg == 5'd17);
    assign sum_done = (term_reg == TERMS);
    assign load = busy_reg && out_free && (app_reg || !need_sum || sum_done);
    assign last_load = app_reg || (pos_reg == len - 5'd1);

    // one 16-bit word of pseudo header and header per cycle while busy and the sum is not done
    always_comb
    begin
        case (term_reg)
            4'd0:    term_val = own_port_reg;
            4'd1:    term_val = peer_port_reg;
            4'd2:    term_val = seq_reg[31:16];
            4'd3:    term_val = seq_reg[15:0];
            4'd4:    term_val = ack_reg[31:16];
            4'd5:    term_val = ack_reg[15:0];
            4'd6:    term_val = {hdr_byte, flags_reg};
            4'd7:    term_val = window_size;
            4'd8:    term_val = local_ip[31:16];
            4'd9:    term_val = local_ip[15:0];
            4'd10:   term_val = peer_ip_reg[31:16];
            4'd11:   term_val = peer_ip_reg[15:0];
            4'd12:   term_val = PROTO_TCP + 16'(len);
            4'd13:   term_val = opt_reg ? {OPT_KIND_MSS, OPT_LEN_MSS} : 16'd0;
            4'd14:   term_val = opt_reg ? max_seg_size : 16'd0;
            default: term_val = 16'd0;
        endcase
    end

    assign fold1 = 17'(sum_reg[15:0]) + 17'(sum_reg[19:16]);
    assign fold2 = fold1[15:0] + 16'(fold1[16]);
    assign csum = ~fold2;

    always_comb
    begin
        case (pos_reg)
            5'd0:    byte_sel = own_port_reg[15:8];
            5'd1:    byte_sel = own_port_reg[7:0];
            5'd2:    byte_sel = peer_port_reg[15:8];
            5'd3:    byte_sel = peer_port_reg[7:0];
            5'd4:    byte_sel = seq_reg[31:24];
            5'd5:    byte_sel = seq_reg[23:16];
            5'd6:    byte_sel = seq_reg[15:8];
            5'd7:    byte_sel = seq_reg[7:0];
            5'd8:    byte_sel = ack_reg[31:24];
            5'd9:    byte_sel = ack_reg[23:16];
            5'd10:   byte_sel = ack_reg[15:8];
            5'd11:   byte_sel = ack_reg[7:0];
            5'd12:   byte_sel = hdr_byte;
            5'd13:   byte_sel = flags_reg;
            5'd14:   byte_sel = window_size[15:8];
            5'd15:   byte_sel = window_size[7:0];
            5'd16:   byte_sel = csum[15:8];
            5'd17:   byte_sel = csum[7:0];
            5'd20:   byte_sel = OPT_KIND_MSS;
            5'd21:   byte_sel = OPT_LEN_MSS;
            5'd22:   byte_sel = max_seg_size[15:8];
            5'd23:   byte_sel = max_seg_size[7:0];
            default: byte_sel = 8'd0;
        endcase
        if (app_reg)
        begin
            byte_sel = 8'd0;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        pos_next = pos_reg;
        term_next = term_reg;
        sum_next = sum_reg;
        ovalid_next = ovalid_reg;
        if (busy_reg && !sum_done)
        begin
            term_next = term_reg + 4'd1;
            sum_next = sum_reg + 20'(term_val);
        end
        if (load)
        begin
            pos_next = pos_reg + 5'd1;
            ovalid_next = 1'b1;
            if (last_load)
            begin
                busy_next = 1'b0;
            end
        end
        else if (m_tready)
        begin
            ovalid_next = 1'b0;
        end
        if (req.valid)
        begin
            busy_next = 1'b1;
            pos_next = 5'd0;
            term_next = 4'd0;
            sum_next = 20'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg <= 5'd0;
            term_reg <= 4'd0;
            sum_reg <= 20'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            pos_reg <= pos_next;
            term_reg <= term_next;
            sum_reg <= sum_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            app_reg <= req.app;
            opt_reg <= req.opt;
            own_port_reg <= req.own_port;
            peer_port_reg <= req.peer_port;
            seq_reg <= req.seq;
            ack_reg <= req.ack;
            flags_reg <= req.flags;
            peer_ip_reg <= req.peer_ip;
        end
        if (load)
        begin
            obyte_reg <= byte_sel;
            olast_reg <= last_load;
            okind_reg <= app_reg;
            olen_reg <= app_reg ? 5'd0 : len;
        end
    end

    assign busy = busy_reg;
    assign m_tvalid = ovalid_reg;
    assign m_tdata = {3'b000, olen_reg, obyte_reg};
    assign m_tlast = olast_reg;
    assign m_tuser = okind_reg;

`ifndef SYNTHESIS
    a_req_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid |-> !busy_reg)
        else $error("reply request while a reply is in progress");
    a_csum_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !app_reg && need_sum) |-> sum_done)
        else $error("checksum byte loaded before sum finished");
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pos_reg < len))
        else $error("reply position beyond header length");
    a_app_single: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && okind_reg) |-> (olast_reg && olen_reg == 5'd0))
        else $error("application event word malformed");
`endif

endmodule

// File: tb/tcp_segment_responder_core_tb.sv
`timescale 1ns / 100ps

module tcp_segment_responder_core_tb;

    import tsr_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_BYTES = 60;
    localparam int SEG_KINDS = 10;
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_APP = 1'b1;

    typedef enum int {
        SEG_SYN_OPEN,
        SEG_SYN_CLOSED,
        SEG_FIN,
        SEG_DATA_OPEN,
        SEG_DATA_CLOSED,
        SEG_EMPTY_ACK,
        SEG_BARE_ACK,
        SEG_RESET,
        SEG_NO_FLAGS,
        SEG_ANY_FLAGS
    } seg_kind_t;

    typedef struct {
        logic [7:0]  hb;
        logic        start;
        logic [15:0] total_len;
        logic [31:0] src_ip;
        logic [31:0] isn;
        logic        drain_first;
    } rx_byte_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       kind;
        logic [4:0] len;
    } reply_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;  // header_byte, ip_total_len, peer_ip, isn_value
    logic        s_tuser;  // segment_start
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;  // out_byte, reply_length, zero fill
    logic        m_tlast;  // last_byte
    logic        m_tuser;  // event_kind
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    tcp_segment_responder_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register copies
    logic [31:0] cfg_local_ip;
    logic [15:0] cfg_listen_port;
    logic [15:0] cfg_window;
    logic [15:0] cfg_mss;

    // parser and reply state
    logic [5:0]  parse_pos;
    logic [15:0] seg_src_port;
    logic [15:0] seg_dst_port;
    logic [31:0] seg_seq;
    logic [31:0] seg_ack;
    logic [3:0]  seg_offset;
    logic [7:0]  seg_flags;
    logic [31:0] ans_seq;
    logic [31:0] ans_ack;
    logic [7:0]  ans_flags;

    rx_byte_t    pending_bytes[$];
    reply_word_t expected_words[$];
    rx_byte_t    next_byte;

    int fail_count = 0;
    int stim_bytes = 0;
    int segments_sent = 0;
    int bytes_accepted = 0;
    int reply_words_seen = 0;
    int app_events_seen = 0;
    int quiet_cycles = 0;
    int burst_left = 20;
    int gap_left = 0;
    int ready_span = 0;
    int ready_mode = 0;
    logic [7:0] ready_mask = 8'hFF;
    logic s_took = 1'b0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic send_reply(input logic with_mss, input logic [31:0] src_ip);
        logic [7:0]  hdr [0:23];
        logic [31:0] sum;
        logic [4:0]  len;
        reply_word_t w;
        int i;
        len = with_mss ? LEN_OPT : LEN_PLAIN;
        for (i = 0; i < 24; i++)
            hdr[i] = 8'h00;
        {hdr[0], hdr[1]} = seg_dst_port;
        {hdr[2], hdr[3]} = seg_src_port;
        {hdr[4], hdr[5], hdr[6], hdr[7]} = ans_seq;
        {hdr[8], hdr[9], hdr[10], hdr[11]} = ans_ack;
        hdr[12] = with_mss ? OFFSET_OPT : OFFSET_PLAIN;
        hdr[13] = ans_flags;
        {hdr[14], hdr[15]} = cfg_window;
        if (with_mss)
        begin
            hdr[20] = OPT_KIND_MSS;
            hdr[21] = OPT_LEN_MSS;
            {hdr[22], hdr[23]} = cfg_mss;
        end
        // pseudo header: both addresses, protocol and tcp length
        sum = 32'(cfg_local_ip[31:16]) + 32'(cfg_local_ip[15:0]) + 32'(src_ip[31:16])
            + 32'(src_ip[15:0]) + 32'(PROTO_TCP) + 32'(len);
        for (i = 0; i < len; i += 2)
            sum += {16'h0000, hdr[i], hdr[i + 1]};
        while (sum[31:16] != 16'h0000)
            sum = 32'(sum[15:0]) + 32'(sum[31:16]);
        {hdr[16], hdr[17]} = ~sum[15:0];
        for (i = 0; i < len; i++)
        begin
            w.out_byte = hdr[i];
            w.last = (i == len - 1);
            w.kind = KIND_HEADER;
            w.len = len;
            expected_words.push_back(w);
        end
    endtask

    task automatic answer_segment(input logic [15:0] total_len, input logic [31:0] src_ip,
                                  input logic [31:0] isn);
        int diff;
        logic [31:0] data_len;
        logic with_mss;
        reply_word_t w;
        diff = int'(total_len) - 20 - 4 * int'(seg_offset);
        data_len = (diff < 0) ? 32'd0 : 32'(diff);
        with_mss = 1'b0;
        if ((seg_flags & FL_RST) != 8'h00 || seg_flags == FL_ACK)
            return;
        if ((seg_flags & FL_SYN) != 8'h00)
        begin
            ans_seq = isn;
            ans_ack = seg_seq + 32'd1;
            if (seg_dst_port == cfg_listen_port)
            begin
                ans_flags = FL_SYN | FL_ACK;
                with_mss = 1'b1;
            end
            else
                ans_flags = FL_RST | FL_ACK;
        end
        else if ((seg_flags & FL_FIN) != 8'h00)
        begin
            ans_seq = seg_ack;
            ans_ack = seg_seq + data_len + 32'd1;
            ans_flags = FL_ACK;
        end
        else if ((seg_flags & FL_ACK) != 8'h00)
        begin
            ans_seq = seg_ack;
            ans_ack = seg_seq + data_len;
            if (data_len == 32'd0 || seg_dst_port != cfg_listen_port)
                return;
            ans_flags = FL_FIN | FL_PSH | FL_ACK;
            w.out_byte = 8'h00;
            w.last = 1'b1;
            w.kind = KIND_APP;
            w.len = 5'd0;
            expected_words.push_back(w);
            return;
        end
        send_reply(with_mss, src_ip);
    endtask

    task automatic absorb_header_byte(input logic [7:0] hb, input logic seg_start,
                                      input logic [15:0] total_len, input logic [31:0] src_ip,
                                      input logic [31:0] isn);
        logic [5:0] pos;
        logic [5:0] last_pos;
        if (seg_start)
            parse_pos = 6'd0;
        if (parse_pos == IDLE_INDEX)
            return;
        pos = parse_pos;
        if (pos < 6'd2)
            seg_src_port = {seg_src_port[7:0], hb};
        else if (pos < 6'd4)
            seg_dst_port = {seg_dst_port[7:0], hb};
        else if (pos < 6'd8)
            seg_seq = {seg_seq[23:0], hb};
        else if (pos < 6'd12)
            seg_ack = {seg_ack[23:0], hb};
        else if (pos == 6'd12)
            seg_offset = hb[7:4];
        else if (pos == 6'd13)
            seg_flags = hb;
        last_pos = (seg_offset > 4'd5) ? {seg_offset, 2'b00} - 6'd1 : MIN_END_INDEX;
        if (pos >= MIN_END_INDEX && pos == last_pos)
        begin
            parse_pos = IDLE_INDEX;
            answer_segment(total_len, src_ip, isn);
        end
        else
            parse_pos = pos + 6'd1;
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_LOCAL_IP:     cfg_local_ip = value;
            CFG_LISTEN_PORT:  cfg_listen_port = value[15:0];
            CFG_WINDOW_SIZE:  cfg_window = value[15:0];
            CFG_MAX_SEG_SIZE: cfg_mss = value[15:0];
            default:          ;
        endcase
    endtask

    task automatic set_registers(input logic [31:0] ip, input logic [15:0] port,
                                 input logic [15:0] window, input logic [15:0] mss);
        write_reg(CFG_LOCAL_IP, ip);
        write_reg(CFG_LISTEN_PORT, {16'h0000, port});
        write_reg(CFG_WINDOW_SIZE, {16'h0000, window});
        write_reg(CFG_MAX_SEG_SIZE, {16'h0000, mss});
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_segment(input logic [15:0] src, input logic [15:0] dst,
                               input logic [31:0] seq, input logic [31:0] ack,
                               input logic [3:0] words, input logic [7:0] flags,
                               input logic [15:0] total_len, input logic [31:0] src_ip,
                               input logic [31:0] isn, input logic marked, input int cut,
                               input logic drain_first);
        logic [7:0] hdr [0:59];
        rx_byte_t rec;
        int nbytes;
        int k;
        nbytes = (words > 4'd5) ? 4 * int'(words) : 20;
        if (cut > 0 && cut < nbytes)
            nbytes = cut;
        for (k = 0; k < 60; k++)
            hdr[k] = 8'($urandom);
        {hdr[0], hdr[1]} = src;
        {hdr[2], hdr[3]} = dst;
        {hdr[4], hdr[5], hdr[6], hdr[7]} = seq;
        {hdr[8], hdr[9], hdr[10], hdr[11]} = ack;
        hdr[12][7:4] = words;
        hdr[13] = flags;
        for (k = 0; k < nbytes; k++)
        begin
            rec.hb = hdr[k];
            rec.start = marked && (k == 0);
            // side fields only count on the closing byte
            if (k == nbytes - 1)
            begin
                rec.total_len = total_len;
                rec.src_ip = src_ip;
                rec.isn = isn;
            end
            else
            begin
                rec.total_len = 16'($urandom);
                rec.src_ip = $urandom;
                rec.isn = $urandom;
            end
            rec.drain_first = drain_first && (k == 0);
            pending_bytes.push_back(rec);
            stim_bytes++;
        end
        segments_sent++;
    endtask

    task automatic add_idle_noise(input int count);
        rx_byte_t rec;
        int k;
        for (k = 0; k < count; k++)
        begin
            rec.hb = 8'($urandom);
            rec.start = 1'b0;
            rec.total_len = 16'($urandom);
            rec.src_ip = $urandom;
            rec.isn = $urandom;
            rec.drain_first = 1'b0;
            pending_bytes.push_back(rec);
        end
    endtask

    task automatic random_segment(input seg_kind_t kind);
        logic [3:0]  words;
        logic [7:0]  flags;
        logic [15:0] dst;
        logic [15:0] total_len;
        logic [31:0] seq;
        int hdr_len;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            words = 4'($urandom_range(0, 4));
        else if (pick == 1)
            words = 4'($urandom_range(8, 15));
        else if (pick < 4)
            words = 4'($urandom_range(6, 7));
        else
            words = 4'd5;
        hdr_len = 20 + 4 * int'(words);
        case ($urandom_range(0, 3))
            0:       total_len = 16'($urandom);
            1:       total_len = 16'(hdr_len);
            2:       total_len = 16'($urandom_range(0, hdr_len));
            default: total_len = 16'(hdr_len + $urandom_range(0, 1460));
        endcase
        dst = 16'($urandom);
        if (dst == cfg_listen_port)
            dst ^= 16'h0001;
        seq = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom;
        case (kind)
            SEG_SYN_OPEN:
            begin
                flags = FL_SYN | (8'($urandom) & ~FL_RST);
                dst = cfg_listen_port;
            end
            SEG_SYN_CLOSED:
                flags = FL_SYN | (8'($urandom) & ~FL_RST);
            SEG_FIN:
            begin
                flags = FL_FIN | (8'($urandom) & ~(FL_RST | FL_SYN));
                if ($urandom_range(0, 1) == 0)
                    dst = cfg_listen_port;
            end
            SEG_DATA_OPEN:
            begin
                flags = FL_ACK | FL_PSH | (8'($urandom) & 8'hE0);
                dst = cfg_listen_port;
                total_len = 16'(hdr_len + $urandom_range(1, 1460));
            end
            SEG_DATA_CLOSED:
            begin
                flags = FL_ACK | FL_PSH | (8'($urandom) & 8'hE0);
                total_len = 16'(hdr_len + $urandom_range(1, 1460));
            end
            SEG_EMPTY_ACK:
            begin
                flags = FL_ACK | (8'($urandom) & (FL_PSH | 8'hE0));
                dst = cfg_listen_port;
                total_len = 16'($urandom_range(0, hdr_len));
            end
            SEG_BARE_ACK:
            begin
                flags = FL_ACK;
                dst = cfg_listen_port;
            end
            SEG_RESET:
                flags = FL_RST | 8'($urandom);
            SEG_NO_FLAGS:
                flags = 8'($urandom) & (FL_PSH | 8'hE0);
            default:
                flags = 8'($urandom);
        endcase
        // a segment cut short by a fresh start mark
        if ($urandom_range(0, 5) == 0)
            add_segment(16'($urandom), 16'($urandom), $urandom, $urandom, 4'($urandom),
                        8'($urandom), 16'($urandom), $urandom, $urandom, 1'b1,
                        $urandom_range(1, 19), 1'b0);
        add_segment(16'($urandom), dst, seq, $urandom, words, flags, total_len, $urandom,
                    $urandom, 1'b1, 0, $urandom_range(0, 4) == 0);
        if ($urandom_range(0, 4) == 0)
            add_idle_noise($urandom_range(1, 4));
    endtask

    task automatic wait_for_idle;
        do
            @(posedge clk);
        while (pending_bytes.size() > 0 || s_tvalid || expected_words.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // sender: bursts of random length with random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || s_took))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_bytes.size() > 0 &&
                     !(pending_bytes[0].drain_first && expected_words.size() > 0))
            begin
                next_byte = pending_bytes.pop_front();
                s_tdata <= {next_byte.isn, next_byte.src_ip, next_byte.total_len, next_byte.hb};
                s_tuser <= next_byte.start;
                s_tvalid <= 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: switches between always ready, a rotating mask and coin flips
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (ready_span == 0)
            begin
                ready_mode = $urandom_range(0, 2);
                ready_mask = 8'($urandom_range(1, 255));
                ready_span = $urandom_range(16, 96);
            end
            else
                ready_span--;
            ready_mask = {ready_mask[6:0], ready_mask[7]};
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ready_mask[0];
                default: m_tready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            s_took <= 1'b0;
        else
        begin
            s_took <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                absorb_header_byte(s_tdata[7:0], s_tuser, s_tdata[23:8], s_tdata[55:24],
                                   s_tdata[87:56]);
                bytes_accepted++;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected word: out_byte %0h last %0b kind %0b length %0d",
                           m_tdata[7:0], m_tlast, m_tuser, m_tdata[12:8]);
                    fail_count++;
                end
                else
                begin
                    if (m_tdata[7:0] != expected_words[0].out_byte)
                    begin
                        $error("out_byte mismatch: expected %0h, actual %0h",
                               expected_words[0].out_byte, m_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_tlast != expected_words[0].last)
                    begin
                        $error("last_byte mismatch: expected %0b, actual %0b",
                               expected_words[0].last, m_tlast);
                        fail_count++;
                    end
                    if (m_tuser != expected_words[0].kind)
                    begin
                        $error("event_kind mismatch: expected %0b, actual %0b",
                               expected_words[0].kind, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[12:8] != expected_words[0].len)
                    begin
                        $error("reply_length mismatch: expected %0d, actual %0d",
                               expected_words[0].len, m_tdata[12:8]);
                        fail_count++;
                    end
                    if (expected_words[0].kind == KIND_APP)
                        app_events_seen++;
                    else
                        reply_words_seen++;
                    void'(expected_words.pop_front());
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("stalled for %0d cycles with %0d words outstanding",
                 quiet_cycles, expected_words.size());
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int phase_goal;
        int kind_cursor;
        int phase;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_LOCAL_IP;
        cfg_data = 32'd0;

        cfg_local_ip = 32'd0;
        cfg_listen_port = LISTEN_PORT_RST;
        cfg_window = 16'd0;
        cfg_mss = MSS_RST;
        parse_pos = 6'd0;
        seg_src_port = 16'd0;
        seg_dst_port = 16'd0;
        seg_seq = 32'd0;
        seg_ack = 32'd0;
        seg_offset = 4'd0;
        seg_flags = 8'd0;
        ans_seq = 32'd0;
        ans_ack = 32'd0;
        ans_flags = 8'd0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // unmarked syn right after reset, at the default listen port and mss
        add_segment(16'hFFFF, LISTEN_PORT_RST, 32'hFFFF_FFFF, 32'd0, 4'd5, FL_SYN,
                    16'd40, 32'hC0A8_0001, 32'h0000_0000, 1'b0, 0, 1'b0);
        add_idle_noise(3);

        kind_cursor = $urandom_range(0, SEG_KINDS - 1);
        phase_goal = stim_bytes;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                1: set_registers(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: set_registers(32'h0000_0000, 16'h0000, 16'h0000, 16'h0000);
                3: set_registers($urandom, 16'($urandom), 16'($urandom), 16'($urandom));
                default: ;
            endcase
            phase_goal += PHASE_BYTES;
            while (stim_bytes < phase_goal)
            begin
                random_segment(seg_kind_t'(kind_cursor % SEG_KINDS));
                kind_cursor++;
            end
            wait_for_idle();
        end

        $display("%0d header bytes in %0d segments over 4 register settings", bytes_accepted,
                 segments_sent);
        $display("checked %0d reply words and %0d application events", reply_words_seen,
                 app_events_seen);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
